FILE: hw/rtl/cma_pkg.sv
// ----------------------------------------------------------------------------
// cma_pkg
// Shared constants, types and state encoding of the centered moving average.
// ----------------------------------------------------------------------------
package cma_pkg;

  localparam int SampleBits = 16;
  localparam int MaxRadius  = 31;
  localparam int RadiusBits = 5;
  localparam int CountBits  = RadiusBits + 1;
  localparam int SpanBits   = RadiusBits + 1;
  localparam int RingDepth  = 2 * MaxRadius + 1;
  localparam int PtrBits    = $clog2(RingDepth);
  localparam int CountMax   = (1 << CountBits) - 1;
  localparam int SumBits    = SampleBits + 6;
  localparam int TailBits   = $clog2(MaxRadius + 2);
  localparam int DivCntBits = $clog2(SumBits);

  typedef logic [SampleBits-1:0] sample_t;
  typedef logic [RadiusBits-1:0] radius_t;
  typedef logic [SumBits-1:0]    sum_t;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StUpdate,
    StDivide,
    StMain,
    StTail
  } state_e;

  typedef struct packed {
    logic accept;
    logic rd;
    logic upd;
    logic div_start;
    logic emit_main;
    logic emit_tail;
  } cmd_t;

  typedef struct packed {
    logic has_main;
    logic full;
    logic last;
    logic tail_nz;
    logic tail_one;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

FILE: hw/rtl/cma_if.sv
// ----------------------------------------------------------------------------
// cma_if
// Valid/ready channels of the centered moving average.
// ----------------------------------------------------------------------------
interface cma_in_if;
  logic              valid;
  logic              ready;
  cma_pkg::sample_t  sample;
  logic              last_in;

  modport source (output valid, sample, last_in, input ready);
  modport sink   (input valid, sample, last_in, output ready);
endinterface

interface cma_out_if;
  logic              valid;
  logic              ready;
  cma_pkg::sample_t  average;
  logic              valid_res;
  logic              last_out;

  modport source (output valid, average, valid_res, last_out, input ready);
  modport sink   (input valid, average, valid_res, last_out, output ready);
endinterface

interface cma_cfg_if;
  logic              valid;
  logic              ready;
  cma_pkg::radius_t  radius;

  modport source (output valid, radius, input ready);
  modport sink   (input valid, radius, output ready);
endinterface

FILE: hw/rtl/cma_div.sv
// ----------------------------------------------------------------------------
// cma_div
// Restoring divider, one quotient bit per cycle: window sum by window span.
// ----------------------------------------------------------------------------
module cma_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  cma_pkg::sum_t                 dividend_i,
  input  logic [cma_pkg::SpanBits-1:0]  divisor_i,
  output logic                          busy_o,
  output cma_pkg::sum_t                 quotient_o
);

  logic                            busy_q;
  logic [cma_pkg::DivCntBits-1:0]  cnt_q;
  cma_pkg::sum_t                   acc_q;
  logic [cma_pkg::SpanBits-1:0]    rem_q;
  logic [cma_pkg::SpanBits-1:0]    dsr_q;
  logic [cma_pkg::SpanBits:0]      trial;
  logic                            fits;

  assign trial = {rem_q, acc_q[cma_pkg::SumBits-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= cma_pkg::DivCntBits'(cma_pkg::SumBits - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= {acc_q[cma_pkg::SumBits-2:0], fits};
      rem_q <= fits ? cma_pkg::SpanBits'(trial - {1'b0, dsr_q})
                    : cma_pkg::SpanBits'(trial);
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = acc_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");

endmodule

FILE: hw/rtl/cma_dp.sv
// ----------------------------------------------------------------------------
// cma_dp
// Datapath: sample ring, running sum, stream counters, divider, result register.
// ----------------------------------------------------------------------------
module cma_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cma_pkg::cmd_t      cmd_i,
  output cma_pkg::status_t   status_o,
  input  cma_pkg::sample_t   sample_i,
  input  logic               last_in_i,
  input  logic               cfg_valid_i,
  input  cma_pkg::radius_t   cfg_radius_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cma_pkg::sample_t   average_o,
  output logic               valid_res_o,
  output logic               last_out_o
);

  cma_pkg::sample_t                ring_q [cma_pkg::RingDepth];
  cma_pkg::sample_t                rdata_q;
  cma_pkg::radius_t                radius_q;
  logic [cma_pkg::PtrBits-1:0]     wp_q;
  logic [cma_pkg::CountBits-1:0]   seen_q;
  cma_pkg::sum_t                   sum_q;
  cma_pkg::sum_t                   sum_d;
  cma_pkg::sample_t                s_q;
  logic                            last_q;
  logic [cma_pkg::CountBits-1:0]   n_q;
  logic [cma_pkg::TailBits-1:0]    tail_q;
  logic [cma_pkg::TailBits-1:0]    tail_d;
  logic                            out_valid_q;
  cma_pkg::sample_t                avg_q;
  logic                            vres_q;
  logic                            lout_q;

  logic [cma_pkg::SpanBits-1:0]    span;
  logic [cma_pkg::SpanBits-1:0]    twice_r;
  logic [cma_pkg::PtrBits:0]       old_sum;
  logic [cma_pkg::PtrBits-1:0]     old_addr;
  logic [cma_pkg::PtrBits-1:0]     wp_d;
  logic [cma_pkg::CountBits-1:0]   seen_d;
  logic                            has_main;
  logic                            full;
  logic                            sub_old;
  logic                            div_busy;
  cma_pkg::sum_t                   quotient;
  cma_pkg::sample_t                avg_sat;
  logic                            out_free;

  assign span    = {radius_q, 1'b1};
  assign twice_r = {radius_q, 1'b0};
  assign old_sum = {1'b0, wp_q} + (cma_pkg::PtrBits+1)'(cma_pkg::RingDepth) - {1'b0, span};
  assign old_addr = (old_sum >= (cma_pkg::PtrBits+1)'(cma_pkg::RingDepth))
                  ? cma_pkg::PtrBits'(old_sum - (cma_pkg::PtrBits+1)'(cma_pkg::RingDepth))
                  : old_sum[cma_pkg::PtrBits-1:0];
  assign wp_d    = (wp_q == cma_pkg::PtrBits'(cma_pkg::RingDepth - 1)) ? '0 : wp_q + 1'b1;
  assign seen_d  = (seen_q == cma_pkg::CountBits'(cma_pkg::CountMax)) ? seen_q
                                                                      : seen_q + 1'b1;
  assign has_main = n_q >= cma_pkg::CountBits'(radius_q);
  assign full     = n_q >= twice_r;
  assign sub_old  = n_q >= span;

  assign sum_d = sum_q - (sub_old ? cma_pkg::SumBits'(rdata_q) : '0)
               + cma_pkg::SumBits'(s_q);

  always_comb begin
    tail_d = '0;
    if (last_q) begin
      tail_d = has_main ? cma_pkg::TailBits'(radius_q) : cma_pkg::TailBits'(n_q + 1'b1);
    end
  end

  // ring memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rdata_q <= ring_q[old_addr];
    end
    if (cmd_i.upd) begin
      ring_q[wp_q] <= s_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
    end else if (cfg_valid_i) begin
      radius_q <= cfg_radius_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      s_q    <= sample_i;
      last_q <= last_in_i;
      n_q    <= seen_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      seen_q <= '0;
      wp_q   <= '0;
      tail_q <= '0;
    end else if (cmd_i.upd) begin
      tail_q <= tail_d;
      if (last_q) begin
        sum_q  <= '0;
        seen_q <= '0;
        wp_q   <= '0;
      end else begin
        sum_q  <= sum_d;
        seen_q <= seen_d;
        wp_q   <= wp_d;
      end
    end else if (cmd_i.emit_tail) begin
      tail_q <= tail_q - 1'b1;
    end
  end

  cma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_d),
    .divisor_i  (span),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  assign avg_sat = (|quotient[cma_pkg::SumBits-1:cma_pkg::SampleBits]) ? '1
                 : quotient[cma_pkg::SampleBits-1:0];

  // result register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_main || cmd_i.emit_tail) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_main) begin
      avg_q  <= full ? avg_sat : '0;
      vres_q <= full;
      lout_q <= last_q && (tail_q == '0);
    end else if (cmd_i.emit_tail) begin
      avg_q  <= '0;
      vres_q <= 1'b0;
      lout_q <= tail_q == cma_pkg::TailBits'(1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = avg_q;
  assign valid_res_o = vres_q;
  assign last_out_o  = lout_q;

  assign status_o.has_main = has_main;
  assign status_o.full     = full;
  assign status_o.last     = last_q;
  assign status_o.tail_nz  = tail_q != '0;
  assign status_o.tail_one = tail_q == cma_pkg::TailBits'(1);
  assign status_o.div_busy = div_busy;
  assign status_o.out_free = out_free;

  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q < cma_pkg::PtrBits'(cma_pkg::RingDepth)) else $error("ring pointer out of range");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd && last_q |=> seen_q == '0 && wp_q == '0 && sum_q == '0)
    else $error("stream state not cleared after last");

  a_tail_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= cma_pkg::TailBits'(cma_pkg::MaxRadius + 1)) else $error("tail count overflow");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_main || cmd_i.emit_tail) |-> out_free && !div_busy)
    else $error("result emitted into busy register");

endmodule

FILE: hw/rtl/cma_ctrl.sv
// ----------------------------------------------------------------------------
// cma_ctrl
// Sequencer: read, update, divide when the window is full, then deliver the main and trailing results.
// ----------------------------------------------------------------------------
module cma_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cma_pkg::status_t   status_i,
  output cma_pkg::cmd_t      cmd_o
);

  cma_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cma_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cma_pkg::StIdle: begin
        if (in_valid_i) state_d = cma_pkg::StLoad;
      end
      cma_pkg::StLoad: begin
        state_d = cma_pkg::StUpdate;
      end
      cma_pkg::StUpdate: begin
        if (status_i.has_main) begin
          state_d = status_i.full ? cma_pkg::StDivide : cma_pkg::StMain;
        end else begin
          state_d = status_i.last ? cma_pkg::StTail : cma_pkg::StIdle;
        end
      end
      cma_pkg::StDivide: begin
        if (!status_i.div_busy) state_d = cma_pkg::StMain;
      end
      cma_pkg::StMain: begin
        if (status_i.out_free) begin
          state_d = status_i.tail_nz ? cma_pkg::StTail : cma_pkg::StIdle;
        end
      end
      cma_pkg::StTail: begin
        if (status_i.out_free && status_i.tail_one) state_d = cma_pkg::StIdle;
      end
      default: state_d = cma_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      cma_pkg::StIdle: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      cma_pkg::StLoad: begin
        cmd_o.rd = 1'b1;
      end
      cma_pkg::StUpdate: begin
        cmd_o.upd       = 1'b1;
        cmd_o.div_start = status_i.has_main && status_i.full;
      end
      cma_pkg::StMain: begin
        cmd_o.emit_main = status_i.out_free;
      end
      cma_pkg::StTail: begin
        cmd_o.emit_tail = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  a_single_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.emit_main && cmd_o.emit_tail)) else $error("two results in one cycle");

  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> cmd_o.rd ##1 cmd_o.upd) else $error("item sequence broken");

endmodule

FILE: hw/rtl/centered_moving_average.sv
// ----------------------------------------------------------------------------
// centered_moving_average
// Centered box filter over a sample stream with a configurable radius.
// ----------------------------------------------------------------------------
// One item at a time. An item reads the ring and updates the sum, then, when
// its result has a full window, passes through the bit-serial divider at one
// quotient bit per cycle, then delivers its results, which wait while out_o
// stalls. An early item with no result delivers none, and a last item also
// flushes the trailing positions. The result register lets the next item
// enter while the previous result waits on out_o. The radius is written
// through cfg_i, which is always ready; write it only while idle.
module centered_moving_average (
  input  logic             clk_i,
  input  logic             rst_ni,
  cma_in_if.sink           in_i,
  cma_out_if.source        out_o,
  cma_cfg_if.sink          cfg_i
);

  cma_pkg::cmd_t    cmd;
  cma_pkg::status_t status;

  assign cfg_i.ready = 1'b1;

  cma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cma_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .sample_i     (in_i.sample),
    .last_in_i    (in_i.last_in),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_radius_i (cfg_i.radius),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .average_o    (out_o.average),
    .valid_res_o  (out_o.valid_res),
    .last_out_o   (out_o.last_out)
  );

endmodule
